FILE: rtl/core/wstq_pkg.sv
package wstq_pkg;

	localparam int MAX_QUEUES_DEF  = 4;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int WORD_WIDTH_DEF  = 32;

	localparam int ID_W    = 32;
	localparam int CFG_W   = 3;
	localparam int HINT_W  = 9;
	localparam int HOME_W  = 8;
	localparam int STAT_W  = 2;
	localparam int QIDX_W  = 2;

	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
	localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

	localparam logic [CFG_W-1:0] QUEUES_RESET = 3'd4;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// Galois LFSR, one step
	function automatic logic [31:0] lfsr_step(input logic [31:0] s);
		logic [31:0] n;
		begin
			n = s >> 1;
			if (s[0]) begin
				n = n ^ LFSR_TAPS;
			end
			return n;
		end
	endfunction

endpackage

FILE: rtl/core/work_stealing_task_queues.sv
// Work-stealing task queues. Keeps MAX_QUEUES ring deques of QUEUE_DEPTH
// tasks (id plus WORD_WIDTH-bit payload) in one single-port-write RAM, with
// head pointers and fill counts in flip-flops. One beat in gives one beat
// out, and items are handled one at a time. Every item first runs a
// bit-serial remainder modulo the queues in use over a 35-bit value. Enqueue
// with a hint or random placement needs only that remainder; the next input
// beat is taken once the result has moved to the output register. Computed
// placement (nonzero task count) first runs a 35-bit restoring divider.
// Dequeue scans the queues one per cycle and reads the RAM once; the scan
// stops at the first queue with a task, or after all queues in use when all
// are empty. The divider and the remainder loop set the rate. A result
// register frees the input while a result waits; a second finished item
// waits for it. The store needs no clearing: fill counts keep unwritten
// entries unread.
module work_stealing_task_queues #(
	parameter int MAX_QUEUES  = wstq_pkg::MAX_QUEUES_DEF,
	parameter int QUEUE_DEPTH = wstq_pkg::QUEUE_DEPTH_DEF,
	parameter int WORD_WIDTH  = wstq_pkg::WORD_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_wdata,    // queues_in_use
	input  logic         s_tvalid,
	output logic         s_tready,
	// [0] cmd, [32:1] task_id, [64:33] task_payload, [96:65] task_count,
	// [105:97] queue_hint, [113:106] home_queue, zero fill to 120
	input  logic [119:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [1:0] status, [33:2] out_task_id, [65:34] out_payload, [66] stolen,
	// [68:67] queue_index, zero fill to 72
	output logic [71:0]  m_tdata
);

	localparam int QW  = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
	localparam int DW  = $clog2(QUEUE_DEPTH);
	localparam int FW  = $clog2(QUEUE_DEPTH + 1);
	localparam int NW  = $clog2(MAX_QUEUES + 1);
	localparam int AW  = QW + DW;
	localparam int EW  = wstq_pkg::ID_W + WORD_WIDTH;
	localparam int MW  = wstq_pkg::ID_W + NW;
	localparam int MCW = $clog2(MW + 1);

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_DIV  = 8'b00000010,
		S_MOD  = 8'b00000100,
		S_ENQ  = 8'b00001000,
		S_SCAN = 8'b00010000,
		S_RD   = 8'b00100000,
		S_RDW  = 8'b01000000,
		S_OUT  = 8'b10000000
	} state_t;

	state_t state_q;

	logic [2:0]            cfg_q;
	logic [NW-1:0]         n_act;
	logic [31:0]           lfsr_q;
	logic [DW-1:0]         head_q [MAX_QUEUES];
	logic [FW-1:0]         fill_q [MAX_QUEUES];

	logic                  cmd_q;
	logic [31:0]           id_q;
	logic [WORD_WIDTH-1:0] pay_q;
	logic [MW-1:0]         red_q;     // value being reduced modulo n, MSB first
	logic [MCW-1:0]        mod_cnt_q; // bits of red_q still to shift in
	logic [NW-1:0]         mod_rem_q; // running remainder
	logic [NW:0]           mod_trial;
	logic [QW-1:0]         q_q;
	logic [QW-1:0]         home_q;
	logic [NW-1:0]         scan_q;
	logic [DW-1:0]         slot_q;
	logic                  stolen_q;
	logic [1:0]            status_q;
	logic [EW-1:0]         rd_q;
	logic [68:0]           res_q;     // result register behind m_tdata
	logic                  res_load;

	logic                  div_start;
	logic                  div_done;
	logic [MW-1:0]         div_quot;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [AW-1:0]         ram_raddr;
	logic [EW-1:0]         ram_wdata;
	logic [EW-1:0]         ram_rdata;

	logic                  in_cmd;
	logic [31:0]           in_id;
	logic [31:0]           in_pay;
	logic [31:0]           in_total;
	logic [8:0]            in_hint;
	logic [7:0]            in_home;
	logic [31:0]           lfsr_nx;
	logic [MW-1:0]         n_ext;
	logic [31:0]           out_id;
	logic [31:0]           out_pay;

	assign in_cmd   = s_tdata[0];
	assign in_id    = s_tdata[32:1];
	assign in_pay   = s_tdata[64:33];
	assign in_total = s_tdata[96:65];
	assign in_hint  = s_tdata[105:97];
	assign in_home  = s_tdata[113:106];
	assign lfsr_nx  = wstq_pkg::lfsr_step(lfsr_q);
	assign n_ext    = MW'(n_act);

	// register out of range: 0 acts as 1, above the built count as the count
	always_comb begin
		if (cfg_q == 3'd0) begin
			n_act = NW'(1);
		end else if (32'(cfg_q) > 32'(MAX_QUEUES)) begin
			n_act = NW'(MAX_QUEUES);
		end else begin
			n_act = NW'(cfg_q);
		end
	end

	assign s_tready = (state_q == S_IDLE);

	// computed placement: task_id * n / task_count
	wstq_div #(.NUM_W(MW), .DEN_W(32)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (MW'(in_id) * n_ext),
		.den   (in_total),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign div_start = s_tvalid && s_tready && (in_cmd == wstq_pkg::CMD_ENQ)
		&& in_hint[8] && (in_total != 32'd0);

	wstq_ram #(.WIDTH(EW), .DEPTH(1 << AW)) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// one remainder step: shift in the next bit, subtract n when it fits
	assign mod_trial = {mod_rem_q, red_q[MW-1]};

	// queue of the current scan step (home + scan) mod n
	logic [NW:0]   scan_sum;
	logic [QW-1:0] scan_idx;
	always_comb begin
		scan_sum = (NW+1)'(home_q) + (NW+1)'(scan_q);
		if (scan_sum >= (NW+1)'(n_act)) begin
			scan_sum = scan_sum - (NW+1)'(n_act);
		end
		scan_idx = QW'(scan_sum);
	end

	// ring slots, wrapped at the queue depth
	logic [DW:0]   tail_sum;
	logic [DW:0]   steal_sum;
	logic [DW-1:0] tail_slot;
	logic [DW-1:0] steal_slot;
	logic [DW-1:0] head_nx;
	always_comb begin
		tail_sum = (DW+1)'(head_q[q_q]) + (DW+1)'(fill_q[q_q]);
		if (tail_sum >= (DW+1)'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - (DW+1)'(QUEUE_DEPTH);
		end
		tail_slot = DW'(tail_sum);
		steal_sum = (DW+1)'(head_q[scan_idx]) + (DW+1)'(fill_q[scan_idx]) - 1'b1;
		if (steal_sum >= (DW+1)'(QUEUE_DEPTH)) begin
			steal_sum = steal_sum - (DW+1)'(QUEUE_DEPTH);
		end
		steal_slot = DW'(steal_sum);
		if (head_q[scan_idx] == DW'(QUEUE_DEPTH - 1)) begin
			head_nx = '0;
		end else begin
			head_nx = head_q[scan_idx] + 1'b1;
		end
	end

	assign ram_we    = (state_q == S_ENQ) && (fill_q[q_q] < FW'(QUEUE_DEPTH));
	assign ram_waddr = {q_q, tail_slot};
	assign ram_wdata = {pay_q, id_q};
	assign ram_raddr = {q_q, slot_q};

	// result moves to the output register once that is free or being taken
	assign res_load = (state_q == S_OUT) && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cfg_q   <= wstq_pkg::QUEUES_RESET;
			lfsr_q  <= wstq_pkg::LFSR_SEED;
			m_tvalid <= 1'b0;
			for (int i = 0; i < MAX_QUEUES; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (res_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (in_cmd == wstq_pkg::CMD_DEQ) begin
							state_q <= S_MOD;
						end else if (!in_hint[8]) begin
							state_q <= S_MOD;
						end else if (in_total != 32'd0) begin
							state_q <= S_DIV;
						end else begin
							// random placement: advance, then use the new value
							lfsr_q  <= lfsr_nx;
							state_q <= S_MOD;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_cnt_q == '0) begin
						state_q <= (cmd_q == wstq_pkg::CMD_DEQ) ? S_SCAN : S_ENQ;
					end
				end
				S_ENQ: begin
					if (ram_we) begin
						fill_q[q_q] <= fill_q[q_q] + 1'b1;
					end
					state_q <= S_OUT;
				end
				S_SCAN: begin
					if (scan_q == n_act) begin
						state_q <= S_OUT;
					end else if (fill_q[scan_idx] != '0) begin
						// own queue pops at the head, others are robbed at the tail
						if (scan_q == '0) begin
							head_q[scan_idx] <= head_nx;
						end
						fill_q[scan_idx] <= fill_q[scan_idx] - 1'b1;
						state_q <= S_RD;
					end
				end
				S_RD:  state_q <= S_RDW;
				S_RDW: state_q <= S_OUT;
				S_OUT: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q     <= in_cmd;
				id_q      <= in_id;
				pay_q     <= WORD_WIDTH'(in_pay);
				stolen_q  <= 1'b0;
				status_q  <= wstq_pkg::ST_OK;
				scan_q    <= '0;
				rd_q      <= '0;
				mod_cnt_q <= MCW'(MW);
				mod_rem_q <= '0;
				if (in_cmd == wstq_pkg::CMD_DEQ) begin
					red_q <= MW'(in_home);
				end else if (!in_hint[8]) begin
					red_q <= MW'(in_hint[7:0]);
				end else begin
					red_q <= MW'(lfsr_nx);
				end
			end
			S_DIV: begin
				if (div_done) begin
					red_q <= div_quot;
				end
			end
			S_MOD: begin
				if (mod_cnt_q != '0) begin
					mod_cnt_q <= mod_cnt_q - 1'b1;
					red_q     <= {red_q[MW-2:0], 1'b0};
					if (mod_trial >= (NW+1)'(n_act)) begin
						mod_rem_q <= NW'(mod_trial - (NW+1)'(n_act));
					end else begin
						mod_rem_q <= NW'(mod_trial);
					end
				end else begin
					q_q    <= QW'(mod_rem_q);
					home_q <= QW'(mod_rem_q);
				end
			end
			S_ENQ: begin
				if (!ram_we) begin
					status_q <= wstq_pkg::ST_FULL;
				end
			end
			S_SCAN: begin
				if (scan_q == n_act) begin
					status_q <= wstq_pkg::ST_EMPTY;
					q_q      <= home_q;
				end else if (fill_q[scan_idx] != '0) begin
					q_q <= scan_idx;
					if (scan_q == '0) begin
						slot_q <= head_q[scan_idx];
					end else begin
						slot_q   <= steal_slot;
						stolen_q <= 1'b1;
					end
				end else begin
					scan_q <= scan_q + 1'b1;
				end
			end
			S_RDW: rd_q <= ram_rdata;
			S_OUT: begin
				if (res_load) begin
					res_q <= {2'(q_q), stolen_q, out_pay, out_id, status_q};
				end
			end
			default: ;
		endcase
	end

	assign out_id  = rd_q[31:0];
	assign out_pay = 32'(rd_q[EW-1:32]);
	assign m_tdata = {3'b000, res_q};

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	// state register stays one-hot
	a_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state not one-hot");
	// fill count of queue 0 never exceeds the depth
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[0] <= FW'(QUEUE_DEPTH))
		else $error("fill overflow");

endmodule

FILE: rtl/core/wstq_ram.sv
module wstq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/wstq_div.sv
// Restoring divider, one quotient bit per cycle. done pulses for one cycle
// when quot holds the full quotient.
module wstq_div #(
	parameter int NUM_W = 35,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quot_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q[DEN_W-1:0], quot_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			if (!diff[DEN_W]) begin
				rem_q  <= diff;
				quot_q <= {quot_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quot = quot_q;

endmodule

FILE: dv/wstq_checker.sv
module wstq_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [119:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [71:0]  m_tdata,
	output int           fail_count,
	output int           pending
);

	localparam int NQ = wstq_pkg::MAX_QUEUES_DEF;
	localparam int DEPTH = wstq_pkg::QUEUE_DEPTH_DEF;
	localparam int DUE_N = 16;

	typedef struct packed {
		logic [1:0]  qidx;
		logic        stolen;
		logic [31:0] payload;
		logic [31:0] id;
		wstq_pkg::status_t status;
	} outcome_t;

	logic [31:0] ring_id [NQ][DEPTH];
	logic [31:0] ring_data [NQ][DEPTH];
	int unsigned head_ptr [NQ];
	int unsigned fill [NQ];
	logic [31:0] lfsr;
	logic [2:0] qcfg;
	// expected beats, in order
	outcome_t due_mem [DUE_N];
	int unsigned due_wr = 0;
	int unsigned due_rd = 0;

	assign pending = int'(due_wr - due_rd);

	function automatic int unsigned queues_active();
		if (qcfg == 3'd0) return 1;
		if (32'(qcfg) > NQ) return NQ;
		return 32'(qcfg);
	endfunction

	function automatic outcome_t predict_task_op(input logic [119:0] d);
		outcome_t r;
		int unsigned n, q, home, idx, slot;
		logic [63:0] sel;
		logic [31:0] id, tot;
		logic [8:0] hint;
		r = '0;
		r.status = wstq_pkg::ST_OK;
		n = queues_active();
		id = d[32:1];
		tot = d[96:65];
		hint = d[105:97];
		if (d[0] == wstq_pkg::CMD_ENQ) begin
			if (!hint[8]) sel = 64'(hint);
			else if (tot != 0) sel = (64'(id) * 64'(n)) / 64'(tot);
			else begin
				// LFSR advances only on random placement
				lfsr = wstq_pkg::lfsr_step(lfsr);
				sel = 64'(lfsr);
			end
			q = 32'(sel % 64'(n));
			if (fill[q] >= DEPTH) r.status = wstq_pkg::ST_FULL;
			else begin
				slot = (head_ptr[q] + fill[q]) % DEPTH;
				ring_id[q][slot] = id;
				ring_data[q][slot] = d[64:33];
				fill[q]++;
			end
		end else begin
			home = 32'(d[113:106]) % n;
			q = home;
			r.status = wstq_pkg::ST_EMPTY;
			for (int i = 0; i < n; i++) begin
				idx = (home + i) % n;
				if (fill[idx] != 0) begin
					if (idx == home) begin
						slot = head_ptr[idx];
						head_ptr[idx] = (slot + 1) % DEPTH;
					end else begin
						slot = (head_ptr[idx] + fill[idx] - 1) % DEPTH;
						r.stolen = 1'b1;
					end
					fill[idx]--;
					r.id = ring_id[idx][slot];
					r.payload = ring_data[idx][slot];
					r.status = wstq_pkg::ST_OK;
					q = idx;
					break;
				end
			end
		end
		r.qidx = q[1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want, got;
		if (!arst_n) begin
			for (int i = 0; i < NQ; i++) begin
				head_ptr[i] = 0;
				fill[i] = 0;
			end
			lfsr = wstq_pkg::LFSR_SEED;
			qcfg = wstq_pkg::QUEUES_RESET;
			fail_count = 0;
			due_wr = 0;
			due_rd = 0;
		end else begin
			if (cfg_we) qcfg = cfg_wdata;
			if (s_tvalid && s_tready) begin
				due_mem[due_wr % DUE_N] = predict_task_op(s_tdata);
				due_wr++;
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[68:0];
				if (due_wr == due_rd) begin
					$display("%0t: unexpected beat, expected none actual %h", $realtime, got);
					fail_count++;
				end else begin
					want = due_mem[due_rd % DUE_N];
					due_rd++;
					if (want !== got || m_tdata[71:69] !== 3'b0) begin
						$display("%0t: mismatch expected st=%0d id=%h pl=%h stl=%b q=%0d",
							$realtime, want.status, want.id, want.payload, want.stolen, want.qidx);
						$display("%0t:          actual   st=%0d id=%h pl=%h stl=%b q=%0d",
							$realtime, got.status, got.id, got.payload, got.stolen, got.qidx);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

FILE: dv/tb_work_stealing_task_queues.sv
module tb_work_stealing_task_queues;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [119:0] s_tdata = '0;   // cmd, id, payload, total, hint, home from bit 0
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [71:0]  m_tdata;        // status, id, payload, stolen, queue_index from bit 0
	int           fail_count;
	int           pending;
	bit           stall_on = 1'b1;
	int           burst_left = 0;

	always #6 clk = ~clk;

	work_stealing_task_queues i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	wstq_checker i_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	// Receiver: random stalls while stall_on is set, always ready otherwise.
	always @(posedge clk) begin
		if (!stall_on) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	// Pack one beat; the caller picks field values.
	function automatic logic [119:0] pack_beat(logic cmd, logic [31:0] id,
		logic [31:0] pl, logic [31:0] tot, logic [8:0] hint, logic [7:0] home);
		return {6'b0, home, hint, tot, pl, id, cmd};
	endfunction

	// Queue count per random phase, out-of-range values included.
	function automatic logic [2:0] phase_queues(input int p);
		case (p)
			0: return 3'd4;
			1: return 3'd1;
			2: return 3'd0;
			3: return 3'd7;
			default: return 3'd2;
		endcase
	endfunction

	// Push one beat, waiting for acceptance; gaps come between bursts.
	// tvalid stays up after a beat so the next beat of a burst follows directly.
	task automatic send_beat(input logic [119:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = int'($urandom_range(0, 6));
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = int'($urandom_range(1, 12));
		end
		s_tdata <= d;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	task automatic drain_all();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic set_queue_count(input logic [2:0] v);
		drain_all();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [119:0] random_enq();
		logic [8:0] hint;
		logic [31:0] tot;
		case ($urandom_range(0, 3))
			0: hint = 9'($urandom_range(0, 255));
			1: hint = 9'h100 | 9'($urandom);
			default: hint = 9'h1FF;
		endcase
		case ($urandom_range(0, 3))
			0: tot = '0;
			1: tot = $urandom;
			default: tot = $urandom_range(1, 64);
		endcase
		return pack_beat(wstq_pkg::CMD_ENQ, $urandom, $urandom, tot, hint, 8'($urandom));
	endfunction

	function automatic logic [119:0] random_deq();
		return pack_beat(wstq_pkg::CMD_DEQ, $urandom, $urandom, $urandom,
			9'($urandom), 8'($urandom));
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pop, hint/compute/random placement, field extremes,
		// overflow of one queue, then pops with stealing.
		send_beat(pack_beat(wstq_pkg::CMD_DEQ, 32'd0, 32'd0, 32'd0, 9'd0, 8'hFF));
		send_beat(pack_beat(wstq_pkg::CMD_ENQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
			9'd255, 8'd0));
		send_beat(pack_beat(wstq_pkg::CMD_ENQ, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
			9'h1FF, 8'd0));
		send_beat(pack_beat(wstq_pkg::CMD_ENQ, 32'h0, 32'h1234_5678, 32'd1, 9'h100, 8'd0));
		send_beat(pack_beat(wstq_pkg::CMD_ENQ, 32'd7, 32'hA5A5_A5A5, 32'd0, 9'h1FF, 8'd0));
		for (int i = 0; i < 17; i++)
			send_beat(pack_beat(wstq_pkg::CMD_ENQ, 32'(i), ~32'(i), 32'd0, 9'd2, 8'd0));
		send_beat(pack_beat(wstq_pkg::CMD_DEQ, 32'd0, 32'd0, 32'd0, 9'd0, 8'd3));
		send_beat(pack_beat(wstq_pkg::CMD_DEQ, 32'd0, 32'd0, 32'd0, 9'd0, 8'd2));

		// Random phases over several queue counts; each starts with a fill-heavy
		// mix and ends draining, so steals and empties come up often.
		for (int p = 0; p < 5; p++) begin
			set_queue_count(phase_queues(p));
			stall_on = (p != 2);
			for (int k = 0; k < 320; k++) begin
				if ($urandom_range(0, 99) < ((k % 160) < 90 ? 70 : 30))
					send_beat(random_enq());
				else
					send_beat(random_deq());
				if (k == 150) drain_all();
			end
		end

		drain_all();
		if (fail_count == 0 && pending == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
